FILE: rtl/core/pbd_pkg.sv
// Shared types, constants and fixed-point helpers for the bend displacement core.
`default_nettype none
package pbd_pkg;

	localparam int unsigned OriginBase = 9;
	localparam int unsigned CoefBase   = 12;
	localparam int unsigned NumLanes   = 9;

	localparam logic [31:0] OneQ16 = 32'h0001_0000;

	localparam logic [2:0] RegLocalEnable = 3'd0;

	localparam logic ActWrite  = 1'b0;
	localparam logic ActVertex = 1'b1;

	typedef logic signed [31:0] q16_t;
	typedef logic signed [63:0] wide_t;
	typedef logic [2:0][31:0] vec3_t;
	typedef logic [NumLanes-1:0][31:0] lanes_t;

	typedef struct packed {
		logic clip;
		logic signed [31:0] val;
	} sat_t;

	// control and payload that ride along the polynomial stages
	typedef struct packed {
		logic  vld;
		logic  clip;
		vec3_t p;
		q16_t  w;
		vec3_t q;
	} side_t;

	function automatic wide_t sx64(input logic [31:0] a);
		return wide_t'(signed'(a));
	endfunction

	// Q16.16 product, floor of product / 2^16
	function automatic wide_t mulq(input logic [31:0] a, input logic [31:0] b);
		wide_t prod;
		prod = sx64(a) * sx64(b);
		return prod >>> 16;
	endfunction

	function automatic sat_t sat32(input wide_t x);
		sat_t r;
		if (x > 64'sh0000_0000_7FFF_FFFF) begin
			r.clip = 1'b1;
			r.val  = 32'sh7FFF_FFFF;
		end else if (x < -64'sh0000_0000_8000_0000) begin
			r.clip = 1'b1;
			r.val  = 32'sh8000_0000;
		end else begin
			r.clip = 1'b0;
			r.val  = x[31:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/pbd_if.sv
// Vertex/load request channel and displacement result channel.
`default_nettype none
interface pbd_req_if;
	logic        valid;
	logic        ready;
	logic        action;
	logic [6:0]  table_index;
	logic signed [31:0] table_value;
	logic signed [31:0] coord_x;
	logic signed [31:0] coord_y;
	logic signed [31:0] coord_z;
	logic signed [31:0] weight;

	modport source (output valid, action, table_index, table_value, coord_x, coord_y,
		coord_z, weight, input ready);
	modport sink (input valid, action, table_index, table_value, coord_x, coord_y,
		coord_z, weight, output ready);
endinterface

interface pbd_rsp_if;
	logic        valid;
	logic        ready;
	logic signed [31:0] disp_x;
	logic signed [31:0] disp_y;
	logic signed [31:0] disp_z;
	logic        saturated;

	modport source (output valid, disp_x, disp_y, disp_z, saturated, input ready);
	modport sink (input valid, disp_x, disp_y, disp_z, saturated, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/pbd_table.sv
// Settings table: frame, origin and polynomial coefficients in flops.
`default_nettype none
module pbd_table import pbd_pkg::*; #(
	parameter int unsigned DEPTH = 84
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        we,
	input  wire logic [6:0]  widx,
	input  wire logic [31:0] wdata,
	output logic [31:0]      tab [DEPTH]
);

	for (genvar i = 0; i < DEPTH; i++) begin : g_word
		localparam logic [31:0] RstVal = (i == 0 || i == 4 || i == 8) ? OneQ16 : 32'd0;
		logic [31:0] word_q;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				word_q <= RstVal;
			end else if (we && (32'(widx) == 32'(i))) begin
				word_q <= wdata;
			end
		end

		assign tab[i] = word_q;
	end

endmodule
`default_nettype wire

FILE: rtl/core/pbd_horner.sv
// One Horner step for all nine polynomials, registered.
`default_nettype none
module pbd_horner import pbd_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	input  wire logic   en,
	input  wire side_t  side_in,
	input  wire lanes_t acc_in,
	input  wire lanes_t coef,
	output side_t       side_out,
	output lanes_t      acc_out
);

	lanes_t nxt_acc;
	logic [NumLanes-1:0] lane_clip;

	logic  vld_q;
	logic  clip_q;
	vec3_t p_q;
	q16_t  w_q;
	vec3_t qv_q;

	always_comb begin
		sat_t r;
		for (int l = 0; l < NumLanes; l++) begin
			r = sat32(mulq(acc_in[l], side_in.q[l % 3]) + sx64(coef[l]));
			nxt_acc[l]   = r.val;
			lane_clip[l] = r.clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= side_in.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clip_q  <= side_in.clip | (|lane_clip);
			p_q     <= side_in.p;
			w_q     <= side_in.w;
			qv_q    <= side_in.q;
			acc_out <= nxt_acc;
		end
	end

	assign side_out = '{vld: vld_q, clip: clip_q, p: p_q, w: w_q, q: qv_q};

endmodule
`default_nettype wire

FILE: rtl/core/polynomial_bend_displacement.sv
// Top level of the polynomial bend displacement pipeline.
// Vertex items stream through a pipeline of MAX_DEGREE+5 register stages and one
// vertex can enter every cycle unless the result side stalls. With local_enable
// set, stage 1 takes p - o, stage 2 rotates into the local frame, one stage per
// Horner step evaluates all nine polynomials in parallel, then the weight
// multiply, q + v, and the inverse rotation that loads the output register. A
// stall at the result side freezes the whole pipeline. Load items write one
// table word at the transfer edge, but are held off until no vertex is in
// flight, so a vertex always sees the table as it stood when it entered; a load
// therefore costs the pipeline drain time. local_enable sits at APB address 0.
`default_nettype none
module polynomial_bend_displacement import pbd_pkg::*; #(
	parameter int unsigned MAX_DEGREE = 7
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	pbd_req_if.sink          req,
	pbd_rsp_if.source        rsp,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int unsigned NCoef = MAX_DEGREE + 1;
	localparam int unsigned Depth = CoefBase + NumLanes * NCoef;

	// ---------------- configuration ----------------
	logic local_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == RegLocalEnable) begin
			local_q <= pwdata[0];
		end
	end

	assign prdata = (paddr == RegLocalEnable) ? {31'd0, local_q} : 32'd0;

	// ---------------- flow control ----------------
	logic adv, busy, tab_we, vtx_in;
	logic [31:0] tab [Depth];

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	side_t  side_c [MAX_DEGREE+1];
	lanes_t acc_c  [MAX_DEGREE+1];
	logic [MAX_DEGREE:0] chain_vld;

	for (genvar g = 0; g <= MAX_DEGREE; g++) begin : g_vld
		assign chain_vld[g] = side_c[g].vld;
	end

	// whole pipeline moves when the output register can be refilled
	assign adv  = !vld_s5 || rsp.ready;
	assign busy = vld_s1 | (|chain_vld) | vld_s3 | vld_s4 | vld_s5;

	assign req.ready = adv && (req.action == ActVertex || !busy);
	assign tab_we    = req.valid && req.ready && req.action == ActWrite;
	assign vtx_in    = req.valid && req.ready && req.action == ActVertex;

	pbd_table #(.DEPTH(Depth)) u_table (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (tab_we),
		.widx  (req.table_index),
		.wdata (req.table_value),
		.tab   (tab)
	);

	// ---------------- stage 1: t = p - o ----------------
	vec3_t p_s1, t_s1;
	q16_t  w_s1;
	logic  clip_s1;
	vec3_t t_d;
	logic  clip_t;

	always_comb begin
		sat_t r;
		vec3_t p;
		p = {req.coord_z, req.coord_y, req.coord_x};
		clip_t = 1'b0;
		for (int j = 0; j < 3; j++) begin
			r = sat32(sx64(p[j]) - sx64(tab[OriginBase + j]));
			t_d[j] = local_q ? r.val : p[j];
			clip_t = clip_t | (local_q & r.clip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= vtx_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s1    <= {req.coord_z, req.coord_y, req.coord_x};
			w_s1    <= req.weight;
			t_s1    <= t_d;
			clip_s1 <= clip_t;
		end
	end

	// ---------------- stage 2: q = R t ----------------
	vec3_t p_s2, q_s2;
	q16_t  w_s2;
	logic  clip_s2;
	vec3_t q_d;
	logic  clip_q;

	always_comb begin
		sat_t  r;
		wide_t acc;
		clip_q = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc = mulq(tab[i*3], t_s1[0]) + mulq(tab[i*3+1], t_s1[1])
				+ mulq(tab[i*3+2], t_s1[2]);
			r = sat32(acc);
			q_d[i] = local_q ? r.val : t_s1[i];
			clip_q = clip_q | (local_q & r.clip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s2    <= p_s1;
			w_s2    <= w_s1;
			q_s2    <= q_d;
			clip_s2 <= clip_s1 | clip_q;
		end
	end

	// ---------------- Horner stages ----------------
	// chain entry: top coefficient of every lane
	assign side_c[0] = '{vld: vld_s2, clip: clip_s2, p: p_s2, w: w_s2, q: q_s2};

	for (genvar l = 0; l < NumLanes; l++) begin : g_top
		assign acc_c[0][l] = tab[CoefBase + l*NCoef + MAX_DEGREE];
	end

	for (genvar g = 1; g <= MAX_DEGREE; g++) begin : g_horner
		lanes_t coef;

		for (genvar l = 0; l < NumLanes; l++) begin : g_coef
			assign coef[l] = tab[CoefBase + l*NCoef + (MAX_DEGREE - g)];
		end

		pbd_horner u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (adv),
			.side_in (side_c[g-1]),
			.acc_in  (acc_c[g-1]),
			.coef    (coef),
			.side_out(side_c[g]),
			.acc_out (acc_c[g])
		);
	end

	// ---------------- stage 3: v = sat(sum) * w ----------------
	side_t sd;
	lanes_t pa;
	vec3_t p_s3, q_s3, v_s3;
	logic  clip_s3;
	vec3_t v_d;
	logic  clip_v;

	assign sd = side_c[MAX_DEGREE];
	assign pa = acc_c[MAX_DEGREE];

	always_comb begin
		sat_t rs, rv;
		clip_v = 1'b0;
		for (int i = 0; i < 3; i++) begin
			rs = sat32(sx64(pa[i*3]) + sx64(pa[i*3+1]) + sx64(pa[i*3+2]));
			rv = sat32(mulq(rs.val, sd.w));
			v_d[i] = rv.val;
			clip_v = clip_v | rs.clip | rv.clip;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= sd.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s3    <= sd.p;
			q_s3    <= sd.q;
			v_s3    <= v_d;
			clip_s3 <= sd.clip | clip_v;
		end
	end

	// ---------------- stage 4: u = q + v ----------------
	vec3_t p_s4, u_s4;
	logic  clip_s4;
	vec3_t u_d;
	logic  clip_u;

	always_comb begin
		sat_t r;
		clip_u = 1'b0;
		for (int j = 0; j < 3; j++) begin
			r = sat32(sx64(q_s3[j]) + sx64(v_s3[j]));
			u_d[j] = local_q ? r.val : v_s3[j];
			clip_u = clip_u | (local_q & r.clip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			p_s4    <= p_s3;
			u_s4    <= u_d;
			clip_s4 <= clip_s3 | clip_u;
		end
	end

	// ---------------- stage 5: d = R^T u + o - p, output register ----------------
	vec3_t d_s5;
	logic  clip_s5;
	vec3_t d_d;
	logic  clip_d;

	always_comb begin
		sat_t  r;
		wide_t acc;
		clip_d = 1'b0;
		for (int i = 0; i < 3; i++) begin
			acc = mulq(u_s4[0], tab[i]) + mulq(u_s4[1], tab[3+i]) + mulq(u_s4[2], tab[6+i])
				+ sx64(tab[OriginBase + i]) - sx64(p_s4[i]);
			r = sat32(acc);
			d_d[i] = local_q ? r.val : u_s4[i];
			clip_d = clip_d | (local_q & r.clip);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			d_s5    <= d_d;
			clip_s5 <= clip_s4 | clip_d;
		end
	end

	assign rsp.valid     = vld_s5;
	assign rsp.disp_x    = d_s5[0];
	assign rsp.disp_y    = d_s5[1];
	assign rsp.disp_z    = d_s5[2];
	assign rsp.saturated = clip_s5;

endmodule
`default_nettype wire

FILE: rtl/core/pbd_checker.sv
// Port-level checks for the bend displacement core, bound to the top level.
`default_nettype none
module pbd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        req_action,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [31:0] rsp_disp_x,
	input wire logic        rsp_saturated
);

	// a stalled result stays offered
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its x displacement and saturation flag
	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_disp_x) && $stable(rsp_saturated))
		else $error("result changed while stalled");

	// table loads only go in with the pipeline drained
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !req_action |-> !rsp_valid)
		else $error("table load while a result is pending");

	// a load transfer produces no result behind it
	a_load_no_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && !req_action |=> !rsp_valid)
		else $error("result after table load");

endmodule

bind polynomial_bend_displacement pbd_checker u_pbd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.req_action   (req.action),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_disp_x   (rsp.disp_x),
	.rsp_saturated(rsp.saturated)
);
`default_nettype wire
